/* src/lcdseq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the character LCD nibble write sequencer.
// No dependencies.

package lcdseq_pkg;

   localparam int NUM_W      = 16;
   localparam int NUM_DIGITS = 5;
   localparam int BCD_W      = NUM_DIGITS * 4;
   localparam int DIG_IDX_W  = 3;
   localparam int CNT_W      = 4;
   localparam int INIT_LEN   = 5;

   localparam logic [1:0] MODE_CMD  = 2'd0;
   localparam logic [1:0] MODE_CHAR = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;
   localparam logic [1:0] MODE_INIT = 2'd3;

   localparam logic [14:0] LEAD_INIT_US     = 15'd20000;
   localparam logic [10:0] HOLD_CMD_HIGH_US = 11'd200;
   localparam logic [10:0] HOLD_LOW_US      = 11'd2000;
   localparam logic [3:0]  ASCII_ZERO_HIGH  = 4'h3;

   typedef enum logic [1:0] {
      SRC_REQ,
      SRC_DIGIT,
      SRC_INIT
   } byte_src_type;

   typedef struct packed {
      logic                  load;
      logic                  dabble;
      logic                  emit;
      byte_src_type          src;
      logic [DIG_IDX_W-1:0]  idx;
      logic                  reg_select;
      logic                  low_nibble;
      logic                  first_lead;
      logic                  last;
   } dp_cmd_type;

   typedef struct packed {
      logic                  out_free;
      logic [DIG_IDX_W-1:0]  lead_digit;
   } dp_stat_type;

   function automatic logic [7:0] init_cmd(input logic [DIG_IDX_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'h02;
         3'd1:    b = 8'h28;
         3'd2:    b = 8'h0C;
         3'd3:    b = 8'h06;
         3'd4:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* src/char_lcd_nibble_write_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the character LCD 4-bit write sequencer.
// Depends on lcdseq_pkg, lcdseq_ctrl and lcdseq_dp.
//
//   channel  dir  tdata fields (low bit up)                    tuser          tlast
//   req_     in   value[15:0]                                  mode[1:0]      -
//   rsp_     out  nibble[3:0], lead_us[18:4], hold_us[29:19]   reg_select[0]  last
//
// Command and character requests: accept, then 2 transfers, one a cycle while rsp_ is not stalled.
// Decimal requests: accept, serial BCD conversion, digit scan, then 2 to 10
// transfers. Init requests: accept, then 10 transfers.
// A stalled rsp_ pauses the transfer sequence; req_tready is high only between
// requests. Synchronous active-high reset clears control state only.

module char_lcd_nibble_write_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // nibble[3:0], lead_us[18:4], hold_us[29:19]
   output logic        rsp_tuser,   // reg_select[0]
   output logic        rsp_tlast
);

   lcdseq_pkg::dp_cmd_type  cmd;
   lcdseq_pkg::dp_stat_type stat;

   lcdseq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

   lcdseq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/lcdseq_dp.sv */
`timescale 1ns / 1ps
// Datapath: number register, serial binary to BCD converter, byte select and
// the registered result stage. Depends on lcdseq_pkg.

module lcdseq_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [15:0]               req_value,
   input  lcdseq_pkg::dp_cmd_type    cmd,
   output lcdseq_pkg::dp_stat_type   stat,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   logic [lcdseq_pkg::NUM_W-1:0] bin_ff, bin_in;
   logic [lcdseq_pkg::BCD_W-1:0] bcd_ff, bcd_in, bcd_adj;
   logic                         valid_ff, valid_in;
   logic [3:0]                   nibble_ff, nibble_in;
   logic                         rs_ff, rs_in;
   logic [14:0]                  lead_ff, lead_in;
   logic [10:0]                  hold_ff, hold_in;
   logic                         last_ff, last_in;
   logic [7:0]                   byte_sel;
   logic [3:0]                   digit;
   logic [lcdseq_pkg::DIG_IDX_W-1:0] lead_digit;

   always_comb begin
      for (int i = 0; i < lcdseq_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      lead_digit = '0;
      for (int i = 0; i < lcdseq_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            lead_digit = lcdseq_pkg::DIG_IDX_W'(i);
         end
      end
   end

   always_comb begin
      unique case (cmd.idx)
         3'd0:    digit = bcd_ff[3:0];
         3'd1:    digit = bcd_ff[7:4];
         3'd2:    digit = bcd_ff[11:8];
         3'd3:    digit = bcd_ff[15:12];
         3'd4:    digit = bcd_ff[19:16];
         default: digit = 4'd0;
      endcase
   end

   always_comb begin
      unique case (cmd.src)
         lcdseq_pkg::SRC_REQ:   byte_sel = bin_ff[7:0];
         lcdseq_pkg::SRC_DIGIT: byte_sel = {lcdseq_pkg::ASCII_ZERO_HIGH, digit};
         lcdseq_pkg::SRC_INIT:  byte_sel = lcdseq_pkg::init_cmd(cmd.idx);
         default:               byte_sel = 8'h00;
      endcase
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (cmd.load) begin
         bin_in = req_value[lcdseq_pkg::NUM_W-1:0];
         bcd_in = '0;
      end else if (cmd.dabble) begin
         {bcd_in, bin_in} = {bcd_adj[lcdseq_pkg::BCD_W-2:0], bin_ff, 1'b0};
      end
   end

   assign stat.out_free   = !valid_ff || rsp_tready;
   assign stat.lead_digit = lead_digit;

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      nibble_in = nibble_ff;
      rs_in     = rs_ff;
      lead_in   = lead_ff;
      hold_in   = hold_ff;
      last_in   = last_ff;
      if (cmd.emit) begin
         valid_in  = 1'b1;
         nibble_in = cmd.low_nibble ? byte_sel[3:0] : byte_sel[7:4];
         rs_in     = cmd.reg_select;
         lead_in   = cmd.first_lead ? lcdseq_pkg::LEAD_INIT_US : 15'd0;
         if (cmd.low_nibble) begin
            hold_in = lcdseq_pkg::HOLD_LOW_US;
         end else if (cmd.reg_select) begin
            hold_in = 11'd0;
         end else begin
            hold_in = lcdseq_pkg::HOLD_CMD_HIGH_US;
         end
         last_in   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      bin_ff    <= bin_in;
      bcd_ff    <= bcd_in;
      nibble_ff <= nibble_in;
      rs_ff     <= rs_in;
      lead_ff   <= lead_in;
      hold_ff   <= hold_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, hold_ff, lead_ff, nibble_ff};
   assign rsp_tuser  = rs_ff;
   assign rsp_tlast  = last_ff;

   a_load_clears_bcd: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> bcd_ff == '0)
      else $error("bcd not cleared on load");
   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> valid_ff)
      else $error("emitted transfer not shown");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !cmd.emit)
      else $error("transfer overwritten while stalled");

endmodule

/* src/lcdseq_ctrl.sv */
`timescale 1ns / 1ps
// Controller: request sequencing, conversion step count and transfer order.
// Depends on lcdseq_pkg.

module lcdseq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [1:0]                req_mode,
   output lcdseq_pkg::dp_cmd_type    cmd,
   input  lcdseq_pkg::dp_stat_type   stat
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_SEND = 2'd3;

   localparam logic [lcdseq_pkg::CNT_W-1:0] CONV_LAST =
      lcdseq_pkg::CNT_W'(lcdseq_pkg::NUM_W - 1);
   localparam logic [lcdseq_pkg::DIG_IDX_W-1:0] INIT_LAST =
      lcdseq_pkg::DIG_IDX_W'(lcdseq_pkg::INIT_LEN - 1);

   logic [1:0]                          state_ff, state_in;
   logic [1:0]                          mode_ff, mode_in;
   logic [lcdseq_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [lcdseq_pkg::DIG_IDX_W-1:0]    idx_ff, idx_in;
   logic                                phase_ff, phase_in;
   logic                                byte_last;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      unique case (mode_ff)
         lcdseq_pkg::MODE_NUM:  byte_last = (idx_ff == '0);
         lcdseq_pkg::MODE_INIT: byte_last = (idx_ff == INIT_LAST);
         default:               byte_last = 1'b1;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.idx        = idx_ff;
      cmd.low_nibble = phase_ff;
      cmd.last       = phase_ff && byte_last;
      cmd.first_lead = (mode_ff == lcdseq_pkg::MODE_INIT) && (idx_ff == '0) && !phase_ff;
      unique case (mode_ff)
         lcdseq_pkg::MODE_CMD: begin
            cmd.src        = lcdseq_pkg::SRC_REQ;
            cmd.reg_select = 1'b0;
         end
         lcdseq_pkg::MODE_CHAR: begin
            cmd.src        = lcdseq_pkg::SRC_REQ;
            cmd.reg_select = 1'b1;
         end
         lcdseq_pkg::MODE_NUM: begin
            cmd.src        = lcdseq_pkg::SRC_DIGIT;
            cmd.reg_select = 1'b1;
         end
         default: begin
            cmd.src        = lcdseq_pkg::SRC_INIT;
            cmd.reg_select = 1'b0;
         end
      endcase

      state_in = state_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      phase_in = phase_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               mode_in  = req_mode;
               cnt_in   = '0;
               idx_in   = '0;
               phase_in = 1'b0;
               state_in = (req_mode == lcdseq_pkg::MODE_NUM) ? S_CONV : S_SEND;
            end
         end
         S_CONV: begin
            cmd.dabble = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CONV_LAST) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            idx_in   = stat.lead_digit;
            state_in = S_SEND;
         end
         S_SEND: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               phase_in = !phase_ff;
               if (phase_ff) begin
                  if (byte_last) begin
                     state_in = S_IDLE;
                  end else if (mode_ff == lcdseq_pkg::MODE_NUM) begin
                     idx_in = idx_ff - 1'b1;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= lcdseq_pkg::MODE_CMD;
         cnt_ff   <= '0;
         idx_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
      end
   end

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.out_free)
      else $error("transfer emitted into a full output stage");
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_tvalid) |=> state_ff != S_IDLE)
      else $error("accepted request did not start");
   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND && mode_ff == lcdseq_pkg::MODE_NUM) |->
         idx_ff < lcdseq_pkg::DIG_IDX_W'(lcdseq_pkg::NUM_DIGITS))
      else $error("digit index out of range");
   a_last_on_low: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |-> (phase_ff && $past(state_ff) == S_SEND))
      else $error("last flag on a high nibble");

endmodule

/* verif/lcd_nibble_checker.sv */
`timescale 1ns / 1ps
// Checker for the character LCD nibble write sequencer: watches both stream channels,
// predicts the nibble transfers of each request and compares them in order.
// Depends on lcdseq_pkg.

module lcd_nibble_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // value[15:0]
   input  logic [1:0]  req_tuser,   // mode[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // nibble[3:0], lead_us[18:4], hold_us[29:19]
   input  logic        rsp_tuser,   // reg_select[0]
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending,
   output int          xfers_checked
);

   typedef struct packed {
      logic [3:0]  nibble;
      logic        reg_select;
      logic [14:0] lead_us;
      logic [10:0] hold_us;
      logic        last;
   } lcd_xfer_type;

   localparam logic [7:0] POWER_UP_CMDS [lcdseq_pkg::INIT_LEN] =
      '{8'h02, 8'h28, 8'h0C, 8'h06, 8'h01};
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   lcd_xfer_type expected_xfers[$];

   function automatic void queue_byte(input logic [7:0] b, input logic rs,
                                      input logic [14:0] lead);
      lcd_xfer_type x;
      x.nibble     = b[7:4];
      x.reg_select = rs;
      x.lead_us    = lead;
      x.hold_us    = rs ? 11'd0 : lcdseq_pkg::HOLD_CMD_HIGH_US;
      x.last       = 1'b0;
      expected_xfers.push_back(x);
      x.nibble  = b[3:0];
      x.lead_us = '0;
      x.hold_us = lcdseq_pkg::HOLD_LOW_US;
      expected_xfers.push_back(x);
   endfunction

   function automatic void predict_request(input logic [1:0] mode, input logic [15:0] value);
      int           n;
      int           nd;
      int           digits[lcdseq_pkg::NUM_DIGITS];
      lcd_xfer_type tail;
      unique case (mode)
         lcdseq_pkg::MODE_CMD: begin
            queue_byte(value[7:0], 1'b0, '0);
         end
         lcdseq_pkg::MODE_CHAR: begin
            queue_byte(value[7:0], 1'b1, '0);
         end
         lcdseq_pkg::MODE_NUM: begin
            n  = int'(value);
            nd = 0;
            do begin
               digits[nd] = n % 10;
               n          = n / 10;
               nd++;
            end while (n > 0);
            while (nd > 0) begin
               nd--;
               queue_byte(CHAR_ZERO + 8'(digits[nd]), 1'b1, '0);
            end
         end
         default: begin
            for (int i = 0; i < lcdseq_pkg::INIT_LEN; i++)
               queue_byte(POWER_UP_CMDS[i], 1'b0,
                          (i == 0) ? lcdseq_pkg::LEAD_INIT_US : 15'd0);
         end
      endcase
      tail      = expected_xfers.pop_back();
      tail.last = 1'b1;
      expected_xfers.push_back(tail);
   endfunction

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: rsp %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      lcd_xfer_type exp_x;
      if (reset) begin
         fail_count    = 0;
         xfers_checked = 0;
         expected_xfers.delete();
      end else begin
         if (req_tvalid && req_tready)
            predict_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_xfers.size() == 0) begin
               $display("%0t: unexpected transfer: expected none, actual tdata %h tuser %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               exp_x = expected_xfers.pop_front();
               check_field("nibble", int'(exp_x.nibble), int'(rsp_tdata[3:0]));
               check_field("reg_select", int'(exp_x.reg_select), int'(rsp_tuser));
               check_field("lead_us", int'(exp_x.lead_us), int'(rsp_tdata[18:4]));
               check_field("hold_us", int'(exp_x.hold_us), int'(rsp_tdata[29:19]));
               check_field("last", int'(exp_x.last), int'(rsp_tlast));
               xfers_checked++;
            end
         end
      end
      pending <= expected_xfers.size();
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Top of the LCD nibble write sequencer testbench: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on lcdseq_pkg, the
// sequencer RTL and lcd_nibble_checker.

module testbench;

   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_PER_PHASE = 50;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int pending;
   int xfers_checked;
   int send_idle_pct;
   int rcv_idle_pct;
   int stall_cycles;
   int mode_count[4];

   char_lcd_nibble_write_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   lcd_nibble_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending       (pending),
      .xfers_checked (xfers_checked)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset)
         stall_cycles <= 0;
      else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no request or transfer accepted for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // holds valid across back-to-back requests; lowered only while idling
   task automatic send_request(input logic [1:0] mode, input logic [15:0] value);
      logic got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= mode;
      do begin
         @(negedge clock);
         got = req_tready;
         @(posedge clock);
      end while (!got);
      mode_count[mode]++;
   endtask

   task automatic send_random_request();
      logic [1:0]  mode;
      logic [15:0] value;
      mode  = 2'($urandom_range(3));
      value = 16'($urandom_range(65535));
      if (mode == lcdseq_pkg::MODE_NUM && $urandom_range(1) == 1)
         value = 16'($urandom_range(999));
      send_request(mode, value);
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      send_idle_pct = 15;
      rcv_idle_pct  = 88;
      mode_count    = '{default: 0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(lcdseq_pkg::MODE_INIT, 16'h0000);
      send_request(lcdseq_pkg::MODE_CMD, 16'h0000);
      send_request(lcdseq_pkg::MODE_CMD, 16'h00FF);
      send_request(lcdseq_pkg::MODE_CMD, 16'hFF5A);
      send_request(lcdseq_pkg::MODE_CHAR, 16'h0000);
      send_request(lcdseq_pkg::MODE_CHAR, 16'h00FF);
      send_request(lcdseq_pkg::MODE_CHAR, 16'h0041);
      send_request(lcdseq_pkg::MODE_CHAR, 16'hABCD);
      send_request(lcdseq_pkg::MODE_NUM, 16'd0);
      send_request(lcdseq_pkg::MODE_NUM, 16'd9);
      send_request(lcdseq_pkg::MODE_NUM, 16'd10);
      send_request(lcdseq_pkg::MODE_NUM, 16'd100);
      send_request(lcdseq_pkg::MODE_NUM, 16'd1000);
      send_request(lcdseq_pkg::MODE_NUM, 16'd10000);
      send_request(lcdseq_pkg::MODE_NUM, 16'd12345);
      send_request(lcdseq_pkg::MODE_NUM, 16'd65535);
      send_request(lcdseq_pkg::MODE_INIT, 16'hFFFF);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 15;
               rcv_idle_pct  = 88;
            end
            1: begin
               send_idle_pct = 88;
               rcv_idle_pct  = 15;
            end
            default: begin
               send_idle_pct = 0;
               rcv_idle_pct  = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) send_random_request();
      end

      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d command, %0d character, %0d decimal and %0d init requests,",
               mode_count[lcdseq_pkg::MODE_CMD], mode_count[lcdseq_pkg::MODE_CHAR],
               mode_count[lcdseq_pkg::MODE_NUM], mode_count[lcdseq_pkg::MODE_INIT]);
      $display("%0d nibble transfers compared under three back-pressure mixes.", xfers_checked);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
